/* rtl/rtt_tbl_pkg.sv */
// rtt_tbl_pkg: shared types, constants and operation codes of the server rtt state table
// no dependencies; imported by rtt_tbl_cfg, rtt_tbl_ctrl, rtt_tbl_dp, server_rtt_state_table and tb

package rtt_tbl_pkg;

  localparam int unsigned ServerSlotsDef = 64;
  localparam int unsigned SlotInW        = 6;
  localparam int unsigned FuncW          = 3;
  localparam int unsigned RttW           = 20;
  localparam int unsigned TmoW           = 10;
  localparam int unsigned QryW           = 32;
  localparam int unsigned RttInW         = 32;
  localparam int unsigned CfgAddrW       = 5;
  localparam int unsigned CfgDataW       = 32;
  localparam int unsigned CostSumW       = 22;

  localparam logic [TmoW-1:0] TimeoutCap     = 10'd1000;
  localparam logic [TmoW-1:0] BanTimeouts    = 10'd3;
  localparam logic [TmoW-1:0] CostPerTimeout = 10'd1000;

  // operation codes
  localparam logic [FuncW-1:0] FuncQuery   = 3'd0;
  localparam logic [FuncW-1:0] FuncRtt     = 3'd1;
  localparam logic [FuncW-1:0] FuncTimeout = 3'd2;
  localparam logic [FuncW-1:0] FuncEdns    = 3'd3;
  localparam logic [FuncW-1:0] FuncFlags   = 3'd4;

  // register indexes
  localparam logic [2:0] RegRttInitial = 3'd0;
  localparam logic [2:0] RegRttMax     = 3'd1;
  localparam logic [2:0] RegRttBan     = 3'd2;
  localparam logic [2:0] RegEdnsUnk    = 3'd3;
  localparam logic [2:0] RegLameMask   = 3'd4;

  typedef struct packed {
    logic [RttW-1:0] rtt_initial;
    logic [RttW-1:0] rtt_max;
    logic [RttW-1:0] rtt_ban;
    logic [7:0]      edns_unknown;
    logic [7:0]      lame_mask;
  } rtt_cfg_t;

  typedef struct packed {
    logic [RttW-1:0] srtt;
    logic [RttW-1:0] rttvar;
    logic [TmoW-1:0] timeouts;
    logic [QryW-1:0] queries;
    logic [7:0]      edns_code;
    logic [15:0]     edns_size;
    logic [7:0]      flags;
  } rtt_rec_t;

  // controller to datapath
  typedef struct packed {
    logic clear;   // clear one valid entry
    logic load;    // capture transaction and read its record
    logic update;  // compute new record and write it back
  } rtt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } rtt_sts_t;

endpackage

/* rtl/rtt_tbl_cfg.sv */
// rtt_tbl_cfg: apb configuration registers of the server rtt state table
// depends on rtt_tbl_pkg

module rtt_tbl_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rtt_tbl_pkg::CfgAddrW-1:0]     paddr,
  input  logic [rtt_tbl_pkg::CfgDataW-1:0]     pwdata,
  output logic [rtt_tbl_pkg::CfgDataW-1:0]     prdata,
  output logic                                 pready,
  output rtt_tbl_pkg::rtt_cfg_t                cfg_o
);
  import rtt_tbl_pkg::*;

  rtt_cfg_t   cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegRttInitial: cfg_d.rtt_initial  = pwdata[RttW-1:0];
        RegRttMax:     cfg_d.rtt_max      = pwdata[RttW-1:0];
        RegRttBan:     cfg_d.rtt_ban      = pwdata[RttW-1:0];
        RegEdnsUnk:    cfg_d.edns_unknown = pwdata[7:0];
        RegLameMask:   cfg_d.lame_mask    = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRttInitial: prdata = CfgDataW'(cfg_q.rtt_initial);
      RegRttMax:     prdata = CfgDataW'(cfg_q.rtt_max);
      RegRttBan:     prdata = CfgDataW'(cfg_q.rtt_ban);
      RegEdnsUnk:    prdata = CfgDataW'(cfg_q.edns_unknown);
      RegLameMask:   prdata = CfgDataW'(cfg_q.lame_mask);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rtt_initial  <= 20'd376;
      cfg_q.rtt_max      <= 20'd120000;
      cfg_q.rtt_ban      <= 20'd120000;
      cfg_q.edns_unknown <= 8'd0;
      cfg_q.lame_mask    <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/rtt_tbl_ctrl.sv */
// rtt_tbl_ctrl: sequencing state machine (clear sweep, read, update, result)
// depends on rtt_tbl_pkg

module rtt_tbl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  rtt_tbl_pkg::rtt_sts_t sts_i,
  output rtt_tbl_pkg::rtt_cmd_t cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import rtt_tbl_pkg::*;

  localparam logic [1:0] StClear  = 2'd0;
  localparam logic [1:0] StIdle   = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;
  localparam logic [1:0] StResult = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy_o = (state_q == StClear) || (state_q == StUpdate);
  assign done_o = (state_q == StResult);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:  if (sts_i.clear_last) state_d = StIdle;
      StIdle:   if (accept) state_d = StUpdate;
      StUpdate: state_d = StResult;
      StResult: state_d = accept ? StUpdate : StIdle;
      default:  state_d = StClear;
    endcase
  end

  always_comb begin
    cmd_o.clear  = (state_q == StClear);
    cmd_o.load   = accept;
    cmd_o.update = (state_q == StUpdate);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/rtt_tbl_dp.sv */
// rtt_tbl_dp: record memory, valid memory with clear sweep, estimator update and cost
// depends on rtt_tbl_pkg

module rtt_tbl_dp #(
  parameter int unsigned ServerSlots = rtt_tbl_pkg::ServerSlotsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rtt_tbl_pkg::rtt_cfg_t              cfg_i,
  input  rtt_tbl_pkg::rtt_cmd_t              cmd_i,
  output rtt_tbl_pkg::rtt_sts_t              sts_o,
  input  logic [rtt_tbl_pkg::FuncW-1:0]      func_i,
  input  logic [rtt_tbl_pkg::SlotInW-1:0]    server_slot_i,
  input  logic [rtt_tbl_pkg::RttInW-1:0]     rtt_ms_i,
  input  logic [7:0]                         edns_code_i,
  input  logic [15:0]                        edns_size_i,
  input  logic [7:0]                         flag_bits_i,
  input  logic                               flag_on_i,
  output logic                               found_o,
  output rtt_tbl_pkg::rtt_rec_t              rec_o,
  output logic [rtt_tbl_pkg::RttW-1:0]       cost_o
);
  import rtt_tbl_pkg::*;

  localparam int unsigned SlotW   = $clog2(ServerSlots);
  localparam int unsigned InSlots = 2 ** SlotInW;

  // slot index reduced modulo the table depth
  logic [SlotW-1:0] slot_map [InSlots];
  for (genvar v = 0; v < InSlots; v++) begin : g_map
    localparam int unsigned MapIdx = v % ServerSlots;
    assign slot_map[v] = SlotW'(MapIdx);
  end

  rtt_rec_t         rec_mem   [ServerSlots];
  logic             valid_mem [ServerSlots];

  logic [SlotW-1:0] clr_cnt_q;
  logic [SlotW-1:0] slot_q;
  logic [FuncW-1:0] func_q;
  logic [RttInW-1:0] rtt_ms_q;
  logic [7:0]       edns_code_q;
  logic [15:0]      edns_size_q;
  logic [7:0]       flag_bits_q;
  logic             flag_on_q;
  rtt_rec_t         rd_rec_q;
  logic             rd_valid_q;
  rtt_rec_t         rec_q, rec_d;
  logic             found_q;
  logic             wr_en;

  rtt_rec_t            cur;
  logic [RttW-1:0]     rtt_cl;
  logic signed [RttW:0]   err;
  logic signed [RttW:0]   srtt_s;
  logic [RttW-1:0]     mag;
  logic signed [RttW+1:0] dv;
  logic signed [RttW+1:0] var_s;
  logic [RttW-1:0]     srtt_jk;
  logic [RttW:0]       srtt_dbl;

  logic                 ban;
  logic [CostSumW-1:0]  cost_sum;

  assign sts_o.clear_last = (clr_cnt_q == SlotW'(ServerSlots - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // valid memory: cleared by the sweep, set by writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      valid_mem[clr_cnt_q] <= 1'b0;
    end else if (wr_en) begin
      valid_mem[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[slot_q] <= rec_d;
    end
  end

  // capture transaction and read its record
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q      <= slot_map[server_slot_i];
      func_q      <= func_i;
      rtt_ms_q    <= rtt_ms_i;
      edns_code_q <= edns_code_i;
      edns_size_q <= edns_size_i;
      flag_bits_q <= flag_bits_i;
      flag_on_q   <= flag_on_i;
      rd_rec_q    <= rec_mem[slot_map[server_slot_i]];
      rd_valid_q  <= valid_mem[slot_map[server_slot_i]];
    end
  end

  // current record or defaults
  always_comb begin
    if (rd_valid_q) begin
      cur = rd_rec_q;
    end else begin
      cur.srtt       = cfg_i.rtt_initial;
      cur.rttvar     = cfg_i.rtt_initial >> 1;
      cur.timeouts   = '0;
      cur.queries    = '0;
      cur.edns_code  = cfg_i.edns_unknown;
      cur.edns_size  = '0;
      cur.flags      = '0;
    end
  end

  // jacobson/karels update
  assign rtt_cl = (rtt_ms_q > RttInW'(cfg_i.rtt_max)) ? cfg_i.rtt_max : rtt_ms_q[RttW-1:0];
  assign err    = $signed({1'b0, rtt_cl}) - $signed({1'b0, cur.srtt});
  assign srtt_s = $signed({1'b0, cur.srtt}) + (err >>> 3);
  assign mag    = err[RttW] ? RttW'(-err) : RttW'(err);
  assign dv     = $signed({2'b00, mag}) - $signed({2'b00, cur.rttvar});
  assign var_s  = $signed({2'b00, cur.rttvar}) + (dv >>> 2);
  assign srtt_dbl = {cur.srtt, 1'b0};

  always_comb begin
    rec_d   = cur;
    wr_en   = 1'b0;
    srtt_jk = (cur.queries == '0) ? rtt_cl : srtt_s[RttW-1:0];
    case (func_q)
      FuncRtt: begin
        wr_en          = cmd_i.update;
        rec_d.srtt     = (srtt_jk > cfg_i.rtt_max) ? cfg_i.rtt_max : srtt_jk;
        rec_d.rttvar   = (cur.queries == '0) ? (rtt_cl >> 1) : var_s[RttW-1:0];
        rec_d.timeouts = '0;
        rec_d.queries  = cur.queries + 1'b1;
      end
      FuncTimeout: begin
        wr_en          = cmd_i.update;
        rec_d.timeouts = (cur.timeouts < TimeoutCap) ? cur.timeouts + 1'b1 : cur.timeouts;
        rec_d.srtt     = (srtt_dbl > {1'b0, cfg_i.rtt_max}) ? cfg_i.rtt_max
                                                            : srtt_dbl[RttW-1:0];
        rec_d.queries  = cur.queries + 1'b1;
      end
      FuncEdns: begin
        wr_en            = cmd_i.update;
        rec_d.edns_code  = edns_code_q;
        if (edns_size_q != '0) rec_d.edns_size = edns_size_q;
      end
      FuncFlags: begin
        wr_en       = cmd_i.update;
        rec_d.flags = flag_on_q ? (cur.flags | flag_bits_q) : (cur.flags & ~flag_bits_q);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rec_q   <= rec_d;
      found_q <= rd_valid_q;
    end
  end

  // selection cost from the updated record
  assign ban      = ((rec_q.flags & cfg_i.lame_mask) != '0) || (rec_q.timeouts >= BanTimeouts);
  assign cost_sum = CostSumW'(rec_q.srtt) + CostSumW'(rec_q.rttvar)
                  + CostSumW'(rec_q.timeouts) * CostSumW'(CostPerTimeout);
  assign cost_o   = (ban || (cost_sum > CostSumW'(cfg_i.rtt_ban))) ? cfg_i.rtt_ban
                                                                    : cost_sum[RttW-1:0];
  assign found_o  = found_q;
  assign rec_o    = rec_q;

endmodule

/* rtl/server_rtt_state_table.sv */
// server_rtt_state_table: per-slot rtt state table
// a transaction accepted with start while busy is low is read, then updated and written back;
// its result then shows on done_o, and a new transaction can be accepted while it shows
// reset: async active low; afterwards a sweep clears the valid memory
// with busy high; config writes are taken during the sweep; the receiver cannot stall
// depends on rtt_tbl_pkg, rtt_tbl_cfg, rtt_tbl_ctrl, rtt_tbl_dp

module server_rtt_state_table #(
  parameter int unsigned ServerSlots = rtt_tbl_pkg::ServerSlotsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtt_tbl_pkg::CfgAddrW-1:0]    paddr,
  input  logic [rtt_tbl_pkg::CfgDataW-1:0]    pwdata,
  output logic [rtt_tbl_pkg::CfgDataW-1:0]    prdata,
  output logic                                pready,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic [rtt_tbl_pkg::FuncW-1:0]       func_i,
  input  logic [rtt_tbl_pkg::SlotInW-1:0]     server_slot_i,
  input  logic [rtt_tbl_pkg::RttInW-1:0]      rtt_ms_i,
  input  logic [7:0]                          edns_code_i,
  input  logic [15:0]                         edns_size_i,
  input  logic [7:0]                          flag_bits_i,
  input  logic                                flag_on_i,
  // result side, one cycle strobe
  output logic                                done_o,
  output logic                                found_o,
  output logic [rtt_tbl_pkg::RttW-1:0]        smoothed_rtt_o,
  output logic [rtt_tbl_pkg::RttW-1:0]        rtt_variance_o,
  output logic [rtt_tbl_pkg::TmoW-1:0]        timeout_count_o,
  output logic [rtt_tbl_pkg::QryW-1:0]        query_count_o,
  output logic [7:0]                          edns_state_out_o,
  output logic [15:0]                         edns_limit_o,
  output logic [7:0]                          flags_out_o,
  output logic [rtt_tbl_pkg::RttW-1:0]        cost_o
);
  import rtt_tbl_pkg::*;

  rtt_cfg_t cfg;
  rtt_cmd_t cmd;
  rtt_sts_t sts;
  rtt_rec_t rec;

  // register file: initial/max/ban rtt, unknown edns code, lame flag mask
  rtt_tbl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: clear sweep after reset, then read -> update/write -> result
  rtt_tbl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // record storage and estimator arithmetic
  rtt_tbl_dp #(
    .ServerSlots (ServerSlots)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .server_slot_i (server_slot_i),
    .rtt_ms_i      (rtt_ms_i),
    .edns_code_i   (edns_code_i),
    .edns_size_i   (edns_size_i),
    .flag_bits_i   (flag_bits_i),
    .flag_on_i     (flag_on_i),
    .found_o       (found_o),
    .rec_o         (rec),
    .cost_o        (cost_o)
  );

  // updated record fields straight from the result register
  assign smoothed_rtt_o   = rec.srtt;
  assign rtt_variance_o   = rec.rttvar;
  assign timeout_count_o  = rec.timeouts;
  assign query_count_o    = rec.queries;
  assign edns_state_out_o = rec.edns_code;
  assign edns_limit_o     = rec.edns_size;
  assign flags_out_o      = rec.flags;

`ifndef SYNTHESIS
  // every accepted transaction gives its result strobe after the update state
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing after accepted transaction");

  // a result strobe never repeats back to back
  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // cost saturates at the ban value
  a_cost_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cost_o <= cfg.rtt_ban))
    else $error("cost above ban value");

  // timeout count respects its cap
  a_tmo_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (timeout_count_o <= TimeoutCap))
    else $error("timeout count above cap");
`endif

endmodule

/* tb/tb.sv */
// tb: self-checking bench for server_rtt_state_table, the per-slot rtt estimator record table
// drives events and apb register accesses, predicts every record update and checks each result
// depends on rtt_tbl_pkg and server_rtt_state_table

module tb;
  import rtt_tbl_pkg::*;

  localparam int unsigned Slots       = ServerSlotsDef;
  localparam int unsigned IdleLimit   = 2000;  // cycles with no transaction before giving up
  localparam int unsigned MaxErrLines = 100;
  localparam int unsigned PhaseItems  = 155;
  localparam int unsigned Phases      = 6;

  // register values after reset
  localparam rtt_cfg_t CfgReset = '{
    rtt_initial:  20'd376,
    rtt_max:      20'd120000,
    rtt_ban:      20'd120000,
    edns_unknown: 8'd0,
    lame_mask:    8'd1
  };

  // one event as presented on the command side
  typedef struct {
    logic [FuncW-1:0]   func;
    logic [SlotInW-1:0] slot;
    logic [RttInW-1:0]  rtt_ms;
    logic [7:0]         edns_code;
    logic [15:0]        edns_size;
    logic [7:0]         flag_bits;
    logic               flag_on;
  } rtt_event_t;

  // record and cost the block should report for one event
  typedef struct {
    rtt_event_t      ev;
    logic            found;
    rtt_rec_t        rec;
    logic [RttW-1:0] cost;
  } rtt_outcome_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [CfgDataW-1:0] pwdata  = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                start   = 1'b0;
  logic                busy;
  logic [FuncW-1:0]    func_i        = '0;
  logic [SlotInW-1:0]  server_slot_i = '0;
  logic [RttInW-1:0]   rtt_ms_i      = '0;
  logic [7:0]          edns_code_i   = '0;
  logic [15:0]         edns_size_i   = '0;
  logic [7:0]          flag_bits_i   = '0;
  logic                flag_on_i     = 1'b0;
  logic                done_o;
  logic                found_o;
  logic [RttW-1:0]     smoothed_rtt_o;
  logic [RttW-1:0]     rtt_variance_o;
  logic [TmoW-1:0]     timeout_count_o;
  logic [QryW-1:0]     query_count_o;
  logic [7:0]          edns_state_out_o;
  logic [15:0]         edns_limit_o;
  logic [7:0]          flags_out_o;
  logic [RttW-1:0]     cost_o;

  // bench copy of the register file and the record store
  rtt_cfg_t     cfg_model;
  logic         slot_written [Slots];
  rtt_rec_t     slot_rec     [Slots];
  rtt_outcome_t pending_results [$];

  int unsigned err_count   = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;  // transactions still to send back to back
  int unsigned hot_base    = 0;  // first slot of the busy slot group in random traffic

  server_rtt_state_table dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .server_slot_i    (server_slot_i),
    .rtt_ms_i         (rtt_ms_i),
    .edns_code_i      (edns_code_i),
    .edns_size_i      (edns_size_i),
    .flag_bits_i      (flag_bits_i),
    .flag_on_i        (flag_on_i),
    .done_o           (done_o),
    .found_o          (found_o),
    .smoothed_rtt_o   (smoothed_rtt_o),
    .rtt_variance_o   (rtt_variance_o),
    .timeout_count_o  (timeout_count_o),
    .query_count_o    (query_count_o),
    .edns_state_out_o (edns_state_out_o),
    .edns_limit_o     (edns_limit_o),
    .flags_out_o      (flags_out_o),
    .cost_o           (cost_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MaxErrLines) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  // apply one event to the bench record store and work out what the block must return
  function automatic rtt_outcome_t apply_to_table(input rtt_event_t ev);
    rtt_outcome_t res;
    rtt_rec_t     rec;
    longint       srtt, dev, smp, err, mag, sum;
    logic         wr;
    int unsigned  s;
    s = ev.slot % Slots;
    res.ev    = ev;
    res.found = slot_written[s];
    // a slot with no record reads as the configured defaults
    if (res.found) begin
      rec = slot_rec[s];
    end else begin
      rec.srtt       = cfg_model.rtt_initial;
      rec.rttvar     = cfg_model.rtt_initial >> 1;
      rec.timeouts   = '0;
      rec.queries    = '0;
      rec.edns_code  = cfg_model.edns_unknown;
      rec.edns_size  = '0;
      rec.flags      = '0;
    end
    srtt = rec.srtt;
    dev  = rec.rttvar;
    wr   = 1'b1;
    case (ev.func)
      FuncRtt: begin
        smp = (ev.rtt_ms > cfg_model.rtt_max) ? cfg_model.rtt_max : ev.rtt_ms;
        if (rec.queries == '0) begin
          // first sample seeds the estimate
          srtt = smp;
          dev  = smp >>> 1;
        end else begin
          // jacobson/karels with floor shifts of 3 and 2
          err  = smp - srtt;
          srtt = srtt + (err >>> 3);
          mag  = (err < 0) ? -err : err;
          dev  = dev + ((mag - dev) >>> 2);
        end
        if (srtt > longint'(cfg_model.rtt_max)) srtt = cfg_model.rtt_max;
        rec.timeouts = '0;
        rec.queries  = rec.queries + 1'b1;
      end
      FuncTimeout: begin
        if (rec.timeouts < TimeoutCap) rec.timeouts = rec.timeouts + 1'b1;
        srtt = srtt * 2;
        if (srtt > longint'(cfg_model.rtt_max)) srtt = cfg_model.rtt_max;
        rec.queries = rec.queries + 1'b1;
      end
      FuncEdns: begin
        rec.edns_code = ev.edns_code;
        if (ev.edns_size != '0) rec.edns_size = ev.edns_size;
      end
      FuncFlags: begin
        rec.flags = ev.flag_on ? (rec.flags | ev.flag_bits) : (rec.flags & ~ev.flag_bits);
      end
      default: begin
        wr = 1'b0;  // query and spare codes leave the store alone
      end
    endcase
    rec.srtt   = srtt[RttW-1:0];
    rec.rttvar = dev[RttW-1:0];
    if (wr) begin
      slot_written[s] = 1'b1;
      slot_rec[s]     = rec;
    end
    if ((rec.flags & cfg_model.lame_mask) != '0 || rec.timeouts >= BanTimeouts) begin
      res.cost = cfg_model.rtt_ban;
    end else begin
      sum = longint'(rec.srtt) + longint'(rec.rttvar)
          + longint'(rec.timeouts) * longint'(CostPerTimeout);
      res.cost = (sum > longint'(cfg_model.rtt_ban)) ? cfg_model.rtt_ban : sum[RttW-1:0];
    end
    res.rec = rec;
    return res;
  endfunction

  function automatic rtt_event_t make_event(input logic [FuncW-1:0] f, input int unsigned slot,
                                            input logic [31:0] rtt, input logic [7:0] code,
                                            input logic [15:0] size, input logic [7:0] bits,
                                            input logic on);
    rtt_event_t ev;
    ev.func      = f;
    ev.slot      = SlotInW'(slot);
    ev.rtt_ms    = rtt;
    ev.edns_code = code;
    ev.edns_size = size;
    ev.flag_bits = bits;
    ev.flag_on   = on;
    return ev;
  endfunction

  // random event, mostly on a small group of slots so records build up history
  function automatic rtt_event_t random_event();
    rtt_event_t  ev;
    int unsigned r;
    int          near_max;
    r = $urandom_range(0, 99);
    if (r < 10)      ev.func = FuncQuery;
    else if (r < 45) ev.func = FuncRtt;
    else if (r < 65) ev.func = FuncTimeout;
    else if (r < 75) ev.func = FuncEdns;
    else if (r < 92) ev.func = FuncFlags;
    else             ev.func = FuncFlags + FuncW'($urandom_range(1, 3));  // spare codes
    if ($urandom_range(0, 99) < 80) ev.slot = SlotInW'(hot_base + $urandom_range(0, 7));
    else                            ev.slot = SlotInW'($urandom);
    near_max = int'(cfg_model.rtt_max) + int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0:       ev.rtt_ms = $urandom;
      1:       ev.rtt_ms = '0;
      2:       ev.rtt_ms = '1;
      3:       ev.rtt_ms = (near_max < 0) ? '0 : RttInW'(near_max);
      default: ev.rtt_ms = $urandom_range(0, 3000);
    endcase
    ev.edns_code = 8'($urandom);
    ev.edns_size = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    ev.flag_bits = 8'($urandom);
    ev.flag_on   = 1'($urandom);
    return ev;
  endfunction

  // gap after a transaction: mostly none or short, a few long, some back-to-back bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_fields(input rtt_event_t ev);
    func_i        <= ev.func;
    server_slot_i <= ev.slot;
    rtt_ms_i      <= ev.rtt_ms;
    edns_code_i   <= ev.edns_code;
    edns_size_i   <= ev.edns_size;
    flag_bits_i   <= ev.flag_bits;
    flag_on_i     <= ev.flag_on;
  endtask

  // present one event, wait until the block takes it, record the prediction, then a random gap, maybe none
  task automatic send_event(input rtt_event_t ev);
    int unsigned gap;
    start <= 1'b1;
    drive_fields(ev);
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(apply_to_table(ev));
    gap = pick_gap();
    if (gap != 0) begin
      // junk on the fields while start is low must be ignored
      start <= 1'b0;
      drive_fields(random_event());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop start and wait until every outstanding transaction has reported
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [RttW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CfgDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      RegRttInitial: cfg_model.rtt_initial  = val;
      RegRttMax:     cfg_model.rtt_max      = val;
      RegRttBan:     cfg_model.rtt_ban      = val;
      RegEdnsUnk:    cfg_model.edns_unknown = val[7:0];
      RegLameMask:   cfg_model.lame_mask    = val[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write_all(input rtt_cfg_t c);
    cfg_write(RegRttInitial, c.rtt_initial);
    cfg_write(RegRttMax, c.rtt_max);
    cfg_write(RegRttBan, c.rtt_ban);
    cfg_write(RegEdnsUnk, RttW'(c.edns_unknown));
    cfg_write(RegLameMask, RttW'(c.lame_mask));
  endtask

  // read a register and compare with the bench copy
  task automatic cfg_read_check(input logic [2:0] idx);
    logic [CfgDataW-1:0] want;
    case (idx)
      RegRttInitial: want = CfgDataW'(cfg_model.rtt_initial);
      RegRttMax:     want = CfgDataW'(cfg_model.rtt_max);
      RegRttBan:     want = CfgDataW'(cfg_model.rtt_ban);
      RegEdnsUnk:    want = CfgDataW'(cfg_model.edns_unknown);
      RegLameMask:   want = CfgDataW'(cfg_model.lame_mask);
      default:       want = '0;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== want) begin
      report_error($sformatf("register %0d read 0x%0h expected 0x%0h", idx, prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_read_all();
    for (int i = RegRttInitial; i <= RegLameMask; i++) cfg_read_check(3'(i));
  endtask

  // reset values, all ones, then the low end (one for rtt max and ban), then back to reset values
  task automatic test_config_regs();
    rtt_cfg_t c;
    cfg_read_all();
    c = '{rtt_initial: '1, rtt_max: '1, rtt_ban: '1, edns_unknown: '1, lame_mask: '1};
    cfg_write_all(c);
    cfg_read_all();
    c = '{rtt_initial: '0, rtt_max: 20'd1, rtt_ban: 20'd1, edns_unknown: '0, lame_mask: '0};
    cfg_write_all(c);
    cfg_read_all();
    cfg_write_all(CfgReset);
    cfg_read_all();
  endtask

  // slots with no record read as defaults; query and spare codes create nothing
  task automatic test_unknown_slots();
    send_event(make_event(FuncQuery, 0, '1, '1, '1, '1, 1'b1));
    for (int k = 1; k <= 3; k++) begin
      send_event(make_event(FuncFlags + FuncW'(k), 1, $urandom, 8'($urandom), 16'($urandom),
                            8'($urandom), 1'($urandom)));
    end
    send_event(make_event(FuncQuery, 1, '0, '0, '0, '0, 1'b0));
  endtask

  // seed, drop to zero (negative error), clamp of a huge sample, then a normal update
  task automatic test_rtt_samples();
    send_event(make_event(FuncRtt, 2, 32'd100, '0, '0, '0, 1'b0));
    send_event(make_event(FuncRtt, 2, 32'd0, '0, '0, '0, 1'b0));
    send_event(make_event(FuncRtt, 2, 32'hFFFF_FFFF, '0, '0, '0, 1'b0));
    send_event(make_event(FuncRtt, 2, 32'd50, '0, '0, '0, 1'b0));
  endtask

  // timeouts up to the ban threshold, a sample clearing them, srtt saturation, last slot
  task automatic test_timeouts();
    repeat (3) send_event(make_event(FuncTimeout, 3, '0, '0, '0, '0, 1'b0));
    send_event(make_event(FuncRtt, 3, 32'd200, '0, '0, '0, 1'b0));
    send_event(make_event(FuncRtt, 6, 32'd119999, '0, '0, '0, 1'b0));
    repeat (2) send_event(make_event(FuncTimeout, 6, '0, '0, '0, '0, 1'b0));
    send_event(make_event(FuncTimeout, Slots - 1, '0, '0, '0, '0, 1'b0));
  endtask

  // edns update, then a zero size that keeps the stored one
  task automatic test_edns();
    send_event(make_event(FuncEdns, 4, '0, 8'hFF, 16'hFFFF, '0, 1'b0));
    send_event(make_event(FuncEdns, 4, '0, 8'h00, 16'h0000, '0, 1'b0));
  endtask

  // set all flags (lame, so banned), clear the lame bit, clear the rest
  task automatic test_flags();
    send_event(make_event(FuncFlags, 5, '0, '0, '0, 8'hFF, 1'b1));
    send_event(make_event(FuncFlags, 5, '0, '0, '0, 8'h01, 1'b0));
    send_event(make_event(FuncFlags, 5, '0, '0, '0, 8'hFE, 1'b0));
  endtask

  // random traffic over several register settings, the extremes among them
  task automatic test_random_traffic();
    rtt_cfg_t c;
    for (int phase = 0; phase < Phases; phase++) begin
      wait_idle();
      case (phase)
        0: c = CfgReset;
        1: c = '{rtt_initial: '0, rtt_max: '1, rtt_ban: '1, edns_unknown: '1, lame_mask: '0};
        2: c = '{rtt_initial: '1, rtt_max: 20'd1, rtt_ban: 20'd1,
                 edns_unknown: 8'($urandom), lame_mask: '1};
        3: c = '{rtt_initial: RttW'($urandom_range(0, 3000)),
                 rtt_max: RttW'($urandom_range(200, 5000)),
                 rtt_ban: RttW'($urandom_range(500, 20000)),
                 edns_unknown: 8'($urandom), lame_mask: 8'($urandom)};
        4: c = '{rtt_initial: RttW'($urandom), rtt_max: RttW'($urandom_range(1, 20'hFFFFF)),
                 rtt_ban: RttW'($urandom_range(1, 20'hFFFFF)),
                 edns_unknown: 8'($urandom), lame_mask: 8'($urandom)};
        default: c = '{rtt_initial: 20'd376, rtt_max: 20'd120000, rtt_ban: 20'd3000,
                       edns_unknown: 8'h5A, lame_mask: 8'h80};
      endcase
      cfg_write_all(c);
      hot_base = $urandom_range(0, Slots - 8);
      repeat (PhaseItems) send_event(random_event());
    end
  endtask

  task automatic check_field(input rtt_event_t ev, input string name,
                             input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("slot %0d func %0d %s got 0x%0h expected 0x%0h",
                             ev.slot, ev.func, name, got, want));
    end
  endtask

  // result checker: every strobe must match the oldest outstanding transaction
  always @(posedge clk_i) begin
    rtt_outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_error("result strobe with no transaction outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field(want.ev, "found", found_o, want.found);
        check_field(want.ev, "smoothed_rtt", smoothed_rtt_o, want.rec.srtt);
        check_field(want.ev, "rtt_variance", rtt_variance_o, want.rec.rttvar);
        check_field(want.ev, "timeout_count", timeout_count_o, want.rec.timeouts);
        check_field(want.ev, "query_count", query_count_o, want.rec.queries);
        check_field(want.ev, "edns_code", edns_state_out_o, want.rec.edns_code);
        check_field(want.ev, "edns_limit", edns_limit_o, want.rec.edns_size);
        check_field(want.ev, "flags", flags_out_o, want.rec.flags);
        check_field(want.ev, "cost", cost_o, want.cost);
      end
    end
  end

  // watchdog: any command, result or register transaction restarts the count
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_model = CfgReset;
    for (int i = 0; i < Slots; i++) slot_written[i] = 1'b0;
    // reset held low at the start; the block then sweeps its valid bits with busy high
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_config_regs();
    test_unknown_slots();
    test_rtt_samples();
    test_timeouts();
    test_edns();
    test_flags();
    test_random_traffic();
    wait_idle();
    // wait on to catch any stray result strobe
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
